/* hw/rtl/tsbs_pkg.sv */
// Shared constants, codes and types of the time series bracket search block.
package tsbs_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int STAMP_BITS   = 40;
    localparam int PAYLOAD_BITS = 64;
    localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS     = IDX_BITS + 1;
    localparam int MIN_ENTRIES  = 2;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QFILL_BITS   = QPTR_BITS + 1;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_REWIND = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        op_t                     op;
        logic [STAMP_BITS-1:0]   stamp;
        logic [PAYLOAD_BITS-1:0] payload;
    } item_t;

    typedef struct packed {
        status_t                 status;
        logic [STAMP_BITS-1:0]   before_stamp;
        logic [PAYLOAD_BITS-1:0] before_payload;
        logic [STAMP_BITS-1:0]   after_stamp;
        logic [PAYLOAD_BITS-1:0] after_payload;
    } res_t;

endpackage

/* hw/rtl/tsbs_ram.sv */
// Generic RAM: one write port, one read port with registered read data.
module tsbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/tsbs_front.sv */
// Front part: accepts requests, decodes the command and queues them for the back part.
module tsbs_front import tsbs_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [1:0]              command,
    input  logic [STAMP_BITS-1:0]   stamp,
    input  logic [PAYLOAD_BITS-1:0] payload,
    output logic                    q_valid,
    output item_t                   q_item,
    input  logic                    q_pop
);

    item_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QFILL_BITS-1:0] fill_reg, fill_next;
    logic                  push;
    item_t                 new_item;

    assign req_ready = (fill_reg != QFILL_BITS'(QUEUE_DEPTH));
    assign push      = req_valid && req_ready;
    assign q_valid   = (fill_reg != '0);
    assign q_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.op      = op_t'(command);
        new_item.stamp   = stamp;
        new_item.payload = payload;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !q_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

/* hw/rtl/tsbs_back.sv */
// Back part: table storage, cursor walk and the response register.
module tsbs_back import tsbs_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    input  item_t q_item,
    output logic  q_pop,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output res_t  rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CHKP = 3'b010,
        S_STEP = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;
    logic [IDX_BITS-1:0]     cursor_reg, cursor_next;
    logic [IDX_BITS-1:0]     prev_idx_reg, prev_idx_next;
    logic                    rewound_reg, rewound_next;
    logic [STAMP_BITS-1:0]   t_reg, t_next;
    logic [STAMP_BITS-1:0]   prev_stamp_reg, prev_stamp_next;
    logic [PAYLOAD_BITS-1:0] prev_payload_reg, prev_payload_next;
    logic                    out_valid_reg, out_valid_next;
    res_t                    out_reg, out_next;

    logic                    out_free;
    logic                    load_out;
    res_t                    res;
    logic                    ram_we;
    logic                    ram_re;
    logic [IDX_BITS-1:0]     ram_raddr;
    logic [STAMP_BITS-1:0]   rd_stamp;
    logic [PAYLOAD_BITS-1:0] rd_payload;
    logic [CNT_BITS-1:0]     next_idx;
    logic [CNT_BITS-1:0]     cursor_plus1;

    tsbs_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_BITS-1:0]),
        .wdata (q_item.stamp),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_stamp)
    );

    tsbs_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_BITS-1:0]),
        .wdata (q_item.payload),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_payload)
    );

    assign out_free     = !out_valid_reg || rsp_ready;
    assign next_idx     = {1'b0, prev_idx_reg} + 1'b1;
    assign cursor_plus1 = {1'b0, cursor_reg} + 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        cursor_next       = cursor_reg;
        prev_idx_next     = prev_idx_reg;
        rewound_next      = rewound_reg;
        t_next            = t_reg;
        prev_stamp_next   = prev_stamp_reg;
        prev_payload_next = prev_payload_reg;
        q_pop             = 1'b0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_raddr         = prev_idx_reg;
        load_out          = 1'b0;
        res               = '0;
        res.status        = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.op)
                        OP_APPEND:
                        begin
                            if (out_free)
                            begin
                                q_pop    = 1'b1;
                                load_out = 1'b1;
                                if (count_reg < CNT_BITS'(TABLE_DEPTH))
                                begin
                                    ram_we     = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    res.status = ST_FULL;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            if (count_reg < CNT_BITS'(MIN_ENTRIES))
                            begin
                                if (out_free)
                                begin
                                    q_pop      = 1'b1;
                                    load_out   = 1'b1;
                                    res.status = ST_NOT_FOUND;
                                end
                            end
                            else
                            begin
                                // cursor at the end: rewind before the first read
                                q_pop  = 1'b1;
                                t_next = q_item.stamp;
                                ram_re = 1'b1;
                                if (cursor_plus1 >= count_reg)
                                begin
                                    prev_idx_next = '0;
                                    rewound_next  = 1'b1;
                                    ram_raddr     = '0;
                                end
                                else
                                begin
                                    prev_idx_next = cursor_reg;
                                    rewound_next  = 1'b0;
                                    ram_raddr     = cursor_reg;
                                end
                                state_next = S_CHKP;
                            end
                        end
                        OP_REWIND:
                        begin
                            if (out_free)
                            begin
                                q_pop       = 1'b1;
                                load_out    = 1'b1;
                                cursor_next = '0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (out_free)
                            begin
                                q_pop       = 1'b1;
                                load_out    = 1'b1;
                                cursor_next = '0;
                                count_next  = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CHKP:
            begin
                ram_re = 1'b1;
                if (!rewound_reg && (rd_stamp > t_reg))
                begin
                    // query lies before the cursor: restart at the first entry
                    prev_idx_next = '0;
                    rewound_next  = 1'b1;
                    ram_raddr     = '0;
                end
                else
                begin
                    prev_stamp_next   = rd_stamp;
                    prev_payload_next = rd_payload;
                    ram_raddr         = next_idx[IDX_BITS-1:0];
                    state_next        = S_STEP;
                end
            end
            S_STEP:
            begin
                if (next_idx >= count_reg)
                begin
                    if (out_free)
                    begin
                        load_out    = 1'b1;
                        res.status  = ST_NOT_FOUND;
                        cursor_next = prev_idx_reg;
                        state_next  = S_IDLE;
                    end
                end
                else if ((rd_stamp >= t_reg) && (prev_stamp_reg <= t_reg))
                begin
                    if (out_free)
                    begin
                        load_out    = 1'b1;
                        cursor_next = prev_idx_reg;
                        state_next  = S_IDLE;
                        if (prev_stamp_reg == t_reg)
                        begin
                            res.before_stamp   = prev_stamp_reg;
                            res.before_payload = prev_payload_reg;
                            res.after_stamp    = prev_stamp_reg;
                            res.after_payload  = prev_payload_reg;
                        end
                        else if (rd_stamp == t_reg)
                        begin
                            res.before_stamp   = rd_stamp;
                            res.before_payload = rd_payload;
                            res.after_stamp    = rd_stamp;
                            res.after_payload  = rd_payload;
                        end
                        else
                        begin
                            res.before_stamp   = prev_stamp_reg;
                            res.before_payload = prev_payload_reg;
                            res.after_stamp    = rd_stamp;
                            res.after_payload  = rd_payload;
                        end
                    end
                end
                else if (rd_stamp == t_reg)
                begin
                    if (out_free)
                    begin
                        load_out           = 1'b1;
                        cursor_next        = prev_idx_reg;
                        state_next         = S_IDLE;
                        res.before_stamp   = rd_stamp;
                        res.before_payload = rd_payload;
                        res.after_stamp    = rd_stamp;
                        res.after_payload  = rd_payload;
                    end
                end
                else if (prev_stamp_reg == t_reg)
                begin
                    if (out_free)
                    begin
                        load_out           = 1'b1;
                        cursor_next        = prev_idx_reg;
                        state_next         = S_IDLE;
                        res.before_stamp   = prev_stamp_reg;
                        res.before_payload = prev_payload_reg;
                        res.after_stamp    = prev_stamp_reg;
                        res.after_payload  = prev_payload_reg;
                    end
                end
                else
                begin
                    // slide the pair one entry forward, fetch the new later entry
                    // only when it lies inside the filled part of the table
                    prev_idx_next     = next_idx[IDX_BITS-1:0];
                    prev_stamp_next   = rd_stamp;
                    prev_payload_next = rd_payload;
                    ram_re            = ((next_idx + 1'b1) < count_reg);
                    ram_raddr         = prev_idx_reg + IDX_BITS'(2);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next       = load_out ? res : out_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            prev_idx_reg  <= '0;
            rewound_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            prev_idx_reg  <= prev_idx_next;
            rewound_reg   <= rewound_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg            <= t_next;
        prev_stamp_reg   <= prev_stamp_next;
        prev_payload_reg <= prev_payload_next;
        out_reg          <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // fill count never exceeds the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // a walk only runs on a table with at least two entries
    a_walk_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (count_reg >= CNT_BITS'(MIN_ENTRIES)))
        else $error("walk active with too few entries");

    // the later entry of the pair is at most one past the last entry
    a_pair_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (next_idx <= count_reg))
        else $error("cursor pair beyond table end");

    // the queue is popped only from the idle state
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && (state_reg == S_IDLE)))
        else $error("queue popped outside idle");

endmodule

/* hw/rtl/time_series_bracket_search.sv */
// Top level of the time series bracket search block: front queue plus back walk engine.
//
// Requests enter on req_valid/req_ready with command, stamp and payload. Commands:
// append an entry, query the bracketing pair of a time, rewind the cursor, clear
// the table. Every request yields exactly one response on rsp_valid/rsp_ready with
// status and the before/after stamps and payloads (zero unless a query is found).
// The front part takes requests into a two-deep queue, so it keeps accepting while
// the back part works or while a response waits for the receiver.
// Append, rewind, clear and short-table queries are retired from the idle state; a response is
// visible the cycle after the request leaves the queue. A query reads the cursor entry, then
// walks the pair forward one entry at a time until it brackets the time or meets the end; it
// restarts at entry zero when the query time lies before the cursor entry. The walk rate is
// set by the single registered read port of the table memories: one entry a cycle.
// When the receiver stalls, the response register holds and the back part waits
// before retiring its next request; the queue then fills and req_ready drops.
// Reset empties the table, zeroes the cursor and drops queued requests; the table
// memories are not cleared, only entries below the fill count are ever used.
module time_series_bracket_search import tsbs_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [1:0]              command,
    input  logic [STAMP_BITS-1:0]   stamp,
    input  logic [PAYLOAD_BITS-1:0] payload,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic [1:0]              status,
    output logic [STAMP_BITS-1:0]   before_stamp,
    output logic [PAYLOAD_BITS-1:0] before_payload,
    output logic [STAMP_BITS-1:0]   after_stamp,
    output logic [PAYLOAD_BITS-1:0] after_payload
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;
    res_t  rsp;

    tsbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .command   (command),
        .stamp     (stamp),
        .payload   (payload),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    tsbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // unpack the response into the result fields
    assign status         = rsp.status;
    assign before_stamp   = rsp.before_stamp;
    assign before_payload = rsp.before_payload;
    assign after_stamp    = rsp.after_stamp;
    assign after_payload  = rsp.after_payload;

endmodule

/* tb/time_series_bracket_search_checker.sv */
// Response checker for the time series bracket search block: predicts each response and compares.
`timescale 1ns / 1ps
module time_series_bracket_search_checker import tsbs_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    input  logic                    req_ready,
    input  logic [1:0]              command,
    input  logic [STAMP_BITS-1:0]   stamp,
    input  logic [PAYLOAD_BITS-1:0] payload,
    input  logic                    rsp_valid,
    input  logic                    rsp_ready,
    input  logic [1:0]              status,
    input  logic [STAMP_BITS-1:0]   before_stamp,
    input  logic [PAYLOAD_BITS-1:0] before_payload,
    input  logic [STAMP_BITS-1:0]   after_stamp,
    input  logic [PAYLOAD_BITS-1:0] after_payload,
    output int                      mismatches,
    output int                      pending,
    output int                      checked,
    output int                      hits,
    output int                      misses,
    output int                      rejects
);

    localparam int REPORT_CAP = 40;

    // shadow table, fill count and cursor
    logic [STAMP_BITS-1:0]   tbl_stamp   [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0] tbl_payload [TABLE_DEPTH];
    int                      fill;
    int                      cursor;

    res_t expected_responses[$];

    function automatic res_t bracket_pair(int lo, int hi);
        res_t r;
        r.status         = ST_OK;
        r.before_stamp   = tbl_stamp[lo];
        r.before_payload = tbl_payload[lo];
        r.after_stamp    = tbl_stamp[hi];
        r.after_payload  = tbl_payload[hi];
        return r;
    endfunction

    task automatic locate_bracket(input logic [STAMP_BITS-1:0] t, output res_t r);
        int lo;
        int hi;
        bit done;
        r = '0;
        r.status = ST_NOT_FOUND;
        done = 1'b0;
        if (fill >= MIN_ENTRIES)
        begin
            if (cursor + 1 >= fill || tbl_stamp[cursor] > t)
                cursor = 0;
            lo = cursor;
            hi = lo + 1;
            // later entry is tested for an exact hit first while walking
            while (!done && hi < fill && !(tbl_stamp[hi] >= t && tbl_stamp[lo] <= t))
            begin
                if (tbl_stamp[hi] == t)
                begin
                    r = bracket_pair(hi, hi);
                    done = 1'b1;
                end
                else if (tbl_stamp[lo] == t)
                begin
                    r = bracket_pair(lo, lo);
                    done = 1'b1;
                end
                else
                begin
                    lo++;
                    hi++;
                    cursor = lo;
                end
            end
            // after the walk the earlier entry wins an exact hit
            if (!done && hi < fill)
            begin
                if (tbl_stamp[lo] == t)
                    r = bracket_pair(lo, lo);
                else if (tbl_stamp[hi] == t)
                    r = bracket_pair(hi, hi);
                else
                    r = bracket_pair(lo, hi);
            end
        end
    endtask

    task automatic predict_response(input op_t op, input logic [STAMP_BITS-1:0] t,
                                    input logic [PAYLOAD_BITS-1:0] value, output res_t r);
        r = '0;
        case (op)
            OP_APPEND:
            begin
                if (fill >= TABLE_DEPTH)
                begin
                    r.status = ST_FULL;
                    rejects++;
                end
                else
                begin
                    tbl_stamp[fill]   = t;
                    tbl_payload[fill] = value;
                    fill++;
                end
            end
            OP_QUERY:
            begin
                locate_bracket(t, r);
                if (r.status == ST_OK)
                    hits++;
                else
                    misses++;
            end
            OP_REWIND:
                cursor = 0;
            default:
            begin
                fill   = 0;
                cursor = 0;
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch
        res_t want;
        if (rst_n)
        begin
            // response first: it can only belong to an earlier request
            if (rsp_valid && rsp_ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: response with none expected, expected nothing, actual status %h",
                                 $time, status);
                end
                else
                begin
                    want = expected_responses.pop_front();
                    checked++;
                    compare_field("status", 64'(want.status), 64'(status));
                    compare_field("before_stamp", 64'(want.before_stamp), 64'(before_stamp));
                    compare_field("before_payload", want.before_payload, before_payload);
                    compare_field("after_stamp", 64'(want.after_stamp), 64'(after_stamp));
                    compare_field("after_payload", want.after_payload, after_payload);
                end
            end
            if (req_valid && req_ready)
            begin
                predict_response(op_t'(command), stamp, payload, want);
                expected_responses.push_back(want);
            end
            pending = expected_responses.size();
        end
    end

endmodule

/* tb/time_series_bracket_search_test.sv */
// Top of the bracket search testbench: clock, reset, request and response stimulus, verdict.
`timescale 1ns / 1ps
module time_series_bracket_search_test;
    import tsbs_pkg::*;

    // Run-time guard against a hang. Random segments walk a few dozen entries
    // at most; the full-table pass has nine queries that may walk the whole
    // table.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_ITEMS  = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    logic                    clk;
    logic                    rst_n          = 1'b0;
    logic                    req_valid      = 1'b0;
    logic                    req_ready;
    logic [1:0]              command        = OP_REWIND;
    logic [STAMP_BITS-1:0]   stamp          = '0;
    logic [PAYLOAD_BITS-1:0] payload        = '0;
    logic                    rsp_valid;
    logic                    rsp_ready      = 1'b0;
    logic [1:0]              status;
    logic [STAMP_BITS-1:0]   before_stamp;
    logic [PAYLOAD_BITS-1:0] before_payload;
    logic [STAMP_BITS-1:0]   after_stamp;
    logic [PAYLOAD_BITS-1:0] after_payload;

    int mismatches;
    int pending;
    int checked;
    int hits;
    int misses;
    int rejects;

    int send_idle_pct = 13;     // chance per cycle that the sender holds back
    int recv_idle_pct = 79;     // chance per cycle that the receiver stalls
    int sent_items;
    int cycle_count;

    // stamps appended since the last clear, used to aim queries and appends and to cap the table size
    logic [STAMP_BITS-1:0] planned[$];

    time_series_bracket_search uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .command        (command),
        .stamp          (stamp),
        .payload        (payload),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .before_stamp   (before_stamp),
        .before_payload (before_payload),
        .after_stamp    (after_stamp),
        .after_payload  (after_payload)
    );

    time_series_bracket_search_checker bracket_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .command        (command),
        .stamp          (stamp),
        .payload        (payload),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .before_stamp   (before_stamp),
        .before_payload (before_payload),
        .after_stamp    (after_stamp),
        .after_payload  (after_payload),
        .mismatches     (mismatches),
        .pending        (pending),
        .checked        (checked),
        .hits           (hits),
        .misses         (misses),
        .rejects        (rejects)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // hard stop if the block hangs
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: cycle limit reached with %0d responses outstanding", $time, pending);
        $display("FAILURE");
        $finish;
    end

    // Receiver: a fresh ready decision every falling edge.
    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [STAMP_BITS-1:0] rand_stamp();
        return STAMP_BITS'({$urandom, $urandom});
    endfunction

    function automatic logic [PAYLOAD_BITS-1:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    // Present one request and hold it until accepted. Entered and left at a
    // falling edge; valid stays high on return so back-to-back requests have
    // no bubble unless the idle draw asks for one.
    task automatic send_request(input op_t op, input logic [STAMP_BITS-1:0] t,
                                input logic [PAYLOAD_BITS-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        command   <= op;
        stamp     <= t;
        payload   <= value;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
        sent_items++;
    endtask

    // Hold off the sender until every request has been answered.
    task automatic drain_responses();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // Append one entry after t: mostly small forward steps, some duplicate
    // times, now and then an out-of-order time.
    task automatic append_next(inout logic [STAMP_BITS-1:0] t);
        case ($urandom_range(9))
            0, 1, 2: ;
            3:       t = rand_stamp();
            default: t = t + STAMP_BITS'($urandom_range(1, 500));
        endcase
        send_request(OP_APPEND, t, rand_payload());
        planned.push_back(t);
    endtask

    // Edge cases: empty and one-entry tables, exact hits on first, middle and
    // last entries, duplicate times, field extremes, rewind rule, walk off the
    // end, out-of-order appends, rewind and clear commands.
    task automatic run_directed();
        send_request(OP_QUERY, '0, '0);
        send_request(OP_APPEND, '0, '0);
        send_request(OP_QUERY, '0, {PAYLOAD_BITS{1'b1}});
        send_request(OP_APPEND, 40'd10, {PAYLOAD_BITS{1'b1}});
        send_request(OP_APPEND, 40'd10, 64'h5555_5555_5555_5555);
        send_request(OP_APPEND, STAMP_MAX, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(OP_QUERY, '0, '0);
        send_request(OP_QUERY, 40'd5, '0);
        send_request(OP_QUERY, 40'd10, '0);
        send_request(OP_QUERY, STAMP_MAX, '0);
        send_request(OP_REWIND, STAMP_MAX, {PAYLOAD_BITS{1'b1}});
        send_request(OP_QUERY, 40'd20, '0);
        send_request(OP_QUERY, 40'd3, '0);
        send_request(OP_CLEAR, STAMP_MAX, {PAYLOAD_BITS{1'b1}});
        send_request(OP_QUERY, 40'd10, '0);
        send_request(OP_APPEND, 40'd100, 64'd1);
        send_request(OP_APPEND, 40'd50, 64'd2);
        send_request(OP_APPEND, 40'd200, 64'd3);
        send_request(OP_QUERY, 40'd60, '0);
        send_request(OP_QUERY, 40'd150, '0);
        send_request(OP_QUERY, 40'd250, '0);
        send_request(OP_QUERY, 40'd100, '0);
        send_request(OP_CLEAR, '0, '0);
    endtask

    // One random segment: build a short sorted-ish table, then mostly
    // forward-moving queries with some exact hits, misses on either side,
    // rewinds, late appends and the odd random request.
    task automatic run_segment();
        int n_ent;
        int idx;
        logic [STAMP_BITS-1:0] t;
        logic [STAMP_BITS-1:0] probe;
        op_t op;
        if (planned.size() > 48 || $urandom_range(3) != 0)
        begin
            send_request(OP_CLEAR, rand_stamp(), rand_payload());
            planned.delete();
        end
        case ($urandom_range(9))
            0:       n_ent = 0;
            1:       n_ent = 1;
            default: n_ent = $urandom_range(2, 24);
        endcase
        if (planned.size() != 0)
            t = planned[$];
        else
            case ($urandom_range(3))
                0:       t = '0;
                1:       t = STAMP_MAX - STAMP_BITS'($urandom_range(2000));
                default: t = rand_stamp();
            endcase
        repeat (n_ent) append_next(t);

        probe = (planned.size() != 0) ? planned[0] - STAMP_BITS'($urandom_range(0, 50))
                                      : rand_stamp();
        repeat ($urandom_range(3, 16))
        begin
            idx = (planned.size() != 0) ? $urandom_range(planned.size() - 1) : 0;
            case ($urandom_range(15))
                0:
                begin
                    op = op_t'($urandom_range(3));
                    t  = rand_stamp();
                    send_request(op, t, rand_payload());
                    if (op == OP_CLEAR)
                        planned.delete();
                    else if (op == OP_APPEND)
                        planned.push_back(t);
                end
                1:
                    send_request(OP_REWIND, rand_stamp(), rand_payload());
                2:
                begin
                    t = (planned.size() != 0) ? planned[$] : probe;
                    append_next(t);
                end
                3:
                    send_request(OP_QUERY, (planned.size() != 0) ? planned[idx] : probe,
                                 rand_payload());
                4:
                    send_request(OP_QUERY, rand_stamp(), rand_payload());
                5:
                    send_request(OP_QUERY,
                                 ((planned.size() != 0) ? planned[$] : probe)
                                     + STAMP_BITS'($urandom_range(1, 100)),
                                 rand_payload());
                6:
                    send_request(OP_QUERY,
                                 ((planned.size() != 0) ? planned[0] : probe)
                                     - STAMP_BITS'($urandom_range(1, 100)),
                                 rand_payload());
                default:
                begin
                    probe = probe + STAMP_BITS'($urandom_range(0, 300));
                    send_request(OP_QUERY, probe, rand_payload());
                end
            endcase
        end
    endtask

    // Fill the table to the brim, bounce appends off it, and run queries that
    // walk long distances, including off the end and back through a rewind.
    task automatic run_full_table();
        logic [STAMP_BITS-1:0] base;
        base = STAMP_BITS'($urandom_range(0, 1000));
        send_request(OP_CLEAR, '0, '0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(OP_APPEND, base + STAMP_BITS'(2 * i), rand_payload());
        repeat (3) send_request(OP_APPEND, rand_stamp(), rand_payload());
        send_request(OP_QUERY, base + STAMP_BITS'(2 * 700 + 1), rand_payload());
        send_request(OP_QUERY, base + STAMP_BITS'(2 * 700), rand_payload());
        send_request(OP_QUERY, base + STAMP_BITS'(2 * 701 + 1), rand_payload());
        send_request(OP_QUERY, base + STAMP_BITS'(2 * (TABLE_DEPTH - 1)), rand_payload());
        send_request(OP_QUERY, base + STAMP_BITS'(2 * TABLE_DEPTH + 1000), rand_payload());
        send_request(OP_QUERY, base + STAMP_BITS'(5), rand_payload());
        send_request(OP_QUERY, base, rand_payload());
        send_request(OP_QUERY, base + STAMP_BITS'(2 * (TABLE_DEPTH - 2) + 1), rand_payload());
        send_request(OP_QUERY, rand_stamp(), rand_payload());
        send_request(OP_CLEAR, '0, '0);
        planned.delete();
    endtask

    initial
    begin : stimulus
        int phase_start;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        drain_responses();

        // three idle mixes: sender light / receiver heavy, swapped, none
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 79;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS)
                run_segment();
            if (phase == 2)
                run_full_table();
            drain_responses();
        end

        // late stray responses would show up as unexpected here
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d requests; checked %0d responses (%0d queries bracketed, %0d missed).",
                 sent_items, checked, hits, misses);
        $display("Three idle mixes on both sides, one full table with %0d rejected appends.",
                 rejects);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* time_series_bracket_search.f */
hw/rtl/tsbs_pkg.sv
hw/rtl/tsbs_ram.sv
hw/rtl/tsbs_front.sv
hw/rtl/tsbs_back.sv
hw/rtl/time_series_bracket_search.sv
tb/time_series_bracket_search_checker.sv
tb/time_series_bracket_search_test.sv
